FILE: hw/rtl/sspr_pkg.sv
// Shared types and constants for the servo status packet receiver.
package sspr_pkg;

  // Item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_BYTE  = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Result status codes
  localparam logic [2:0] ST_SUCCESS  = 3'd0;
  localparam logic [2:0] ST_TIMEOUT  = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_OVERFLOW = 3'd3;
  localparam logic [2:0] ST_CORRUPT  = 3'd4;

  // Register indexes (paddr[2])
  localparam logic REG_TIMEOUT      = 1'b0;
  localparam logic REG_LENGTH_LIMIT = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET      = 16'd1000;
  localparam logic [7:0]  LENGTH_LIMIT_RESET = 8'd54;

  localparam logic [7:0] SYNC_BYTE = 8'hFF;

  // Two sync bytes, id and length precede the length-counted bytes
  localparam int PKT_OVERHEAD = 4;
  // Buffer index of the first parameter byte
  localparam int PARAM_BASE   = 5;
  localparam int MAX_RESULTS  = 52;
  localparam int NPW          = $clog2(MAX_RESULTS + 1);

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] rx_byte;
  } item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] servo_id;
    logic [7:0] servo_error;
    logic [7:0] param_byte;
    logic       param_valid;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [7:0]  length_limit;
  } cfg_t;

  // One finished receive attempt handed from front to back
  typedef struct packed {
    logic [2:0]     status;
    logic [7:0]     servo_id;
    logic [7:0]     servo_error;
    logic [NPW-1:0] param_count;
  } job_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } back_state_t;

endpackage

FILE: hw/rtl/sspr_buf.sv
// Packet byte buffer: one write port, one registered read port.
module sspr_buf #(
  parameter int DEPTH = 56,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hw/rtl/sspr_queue.sv
// Short job queue between the packet front end and the result back end.
module sspr_queue #(
  parameter int DEPTH = 2
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  sspr_pkg::job_t push_job,
  input  logic          pop,
  output sspr_pkg::job_t head,
  output logic          full,
  output logic          empty
);

  localparam int PW  = $clog2(DEPTH);
  localparam int CTW = $clog2(DEPTH + 1);

  sspr_pkg::job_t entries [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CTW-1:0] count;

  assign full  = (count == CTW'(DEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CTW'(1);
      end else if (pop && !push) begin
        count <= count - CTW'(1);
      end
    end
  end

  overflow_chk: assert property (@(posedge clk) disable iff (rst) push |-> !full || pop)
    else $error("job pushed into a full queue");
  underflow_chk: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("job popped from an empty queue");

endmodule

FILE: hw/rtl/sspr_front.sv
// Front end: sync hunt, packet capture, checksum and timeout tracking.
module sspr_front #(
  parameter int BUF_BYTES = 56,
  parameter int AW        = $clog2(BUF_BYTES)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            item_valid,
  output logic            item_ready,
  input  sspr_pkg::item_t item,
  input  sspr_pkg::cfg_t  cfg,
  input  logic            q_full,
  output logic            push,
  output sspr_pkg::job_t  push_job,
  output logic            wr_en,
  output logic [AW-1:0]   wr_addr,
  output logic [7:0]      wr_data,
  input  logic            release_buf
);

  localparam int CW = $clog2(BUF_BYTES + 1);
  localparam int LW = (CW > 9) ? CW : 9;

  logic          armed, armed_next;
  logic [1:0]    sync_seen, sync_seen_next;
  logic          in_packet, in_packet_next;
  logic [CW-1:0] byte_count, byte_count_next;
  logic [2:0]    pend_err, pend_err_next;
  logic [15:0]   idle_ticks, idle_ticks_next;
  logic [7:0]    id_reg, id_reg_next;
  logic [7:0]    len_reg, len_reg_next;
  logic [7:0]    err_reg, err_reg_next;
  logic [7:0]    sum_excl, sum_excl_next;
  logic [7:0]    last_byte, last_byte_next;
  logic          locked, locked_next;

  logic          accept;
  logic          pkt_byte;
  logic [7:0]    b;
  logic          store_ok;
  logic [CW-1:0] bc_inc;
  logic [7:0]    len_v;
  logic [7:0]    err_v;
  logic [7:0]    sum_new;
  logic [7:0]    last_new;
  logic          csum_ok;
  logic          at_end;
  logic          past_len;
  logic [7:0]    np_raw;
  logic [7:0]    np_cap;
  logic [15:0]   idle_inc;

  assign item_ready = !q_full && !locked;
  assign accept     = item_valid && item_ready;
  assign b          = item.rx_byte;

  // Packet byte arithmetic, used when the byte belongs to the packet
  assign store_ok = (byte_count < CW'(BUF_BYTES));
  assign bc_inc   = store_ok ? byte_count + CW'(1) : byte_count;
  assign len_v    = (store_ok && byte_count == CW'(3)) ? b : len_reg;
  assign err_v    = (store_ok && byte_count == CW'(4)) ? b : err_reg;
  assign sum_new  = !store_ok ? sum_excl :
                    (byte_count == CW'(2)) ? 8'h00 : 8'(sum_excl + last_byte);
  assign last_new = store_ok ? b : last_byte;
  // Sum of id..last parameter sits in sum_new; checksum byte is last_new
  assign csum_ok  = ((~sum_new) == last_new);
  assign past_len = (bc_inc > CW'(3));
  assign at_end   = (LW'(bc_inc) == (LW'(len_v) + LW'(sspr_pkg::PKT_OVERHEAD)));
  assign np_raw   = (len_v >= 8'd2) ? len_v - 8'd2 : 8'd0;
  assign np_cap   = (np_raw > 8'(sspr_pkg::MAX_RESULTS)) ? 8'(sspr_pkg::MAX_RESULTS) : np_raw;
  assign idle_inc = (idle_ticks != 16'hFFFF) ? idle_ticks + 16'd1 : idle_ticks;

  always_comb begin
    armed_next      = armed;
    sync_seen_next  = sync_seen;
    in_packet_next  = in_packet;
    byte_count_next = byte_count;
    pend_err_next   = pend_err;
    idle_ticks_next = idle_ticks;
    id_reg_next     = id_reg;
    len_reg_next    = len_reg;
    err_reg_next    = err_reg;
    sum_excl_next   = sum_excl;
    last_byte_next  = last_byte;
    locked_next     = locked && !release_buf;
    push            = 1'b0;
    push_job        = '0;
    wr_en           = 1'b0;
    wr_addr         = '0;
    wr_data         = b;
    pkt_byte        = 1'b0;

    if (accept) begin
      unique case (item.mode)
        sspr_pkg::MODE_START: begin
          armed_next      = 1'b1;
          sync_seen_next  = 2'd0;
          in_packet_next  = 1'b0;
          byte_count_next = '0;
          pend_err_next   = sspr_pkg::ST_TIMEOUT;
          idle_ticks_next = 16'd0;
        end
        sspr_pkg::MODE_BYTE: begin
          if (armed) begin
            if (in_packet) begin
              pkt_byte = 1'b1;
            end else if (b == sspr_pkg::SYNC_BYTE) begin
              // third sync byte in a row is dropped
              if (sync_seen < 2'd2) begin
                wr_en           = 1'b1;
                wr_addr         = AW'(sync_seen);
                sync_seen_next  = sync_seen + 2'd1;
                byte_count_next = CW'(sync_seen) + CW'(1);
                idle_ticks_next = 16'd0;
              end
            end else if (sync_seen == 2'd1) begin
              sync_seen_next  = 2'd0;
              byte_count_next = '0;
            end else if (sync_seen == 2'd2) begin
              in_packet_next = 1'b1;
              pkt_byte       = 1'b1;
            end
          end
        end
        sspr_pkg::MODE_TICK: begin
          if (armed) begin
            idle_ticks_next = idle_inc;
            if (idle_inc >= cfg.timeout_ticks) begin
              push               = 1'b1;
              push_job.status    = pend_err;
              armed_next         = 1'b0;
              in_packet_next     = 1'b0;
              sync_seen_next     = 2'd0;
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (pkt_byte) begin
      idle_ticks_next = 16'd0;
      if (store_ok) begin
        wr_en           = 1'b1;
        wr_addr         = byte_count[AW-1:0];
        byte_count_next = bc_inc;
        sum_excl_next   = sum_new;
        last_byte_next  = last_new;
        if (byte_count == CW'(2)) id_reg_next  = b;
        if (byte_count == CW'(3)) len_reg_next = b;
        if (byte_count == CW'(4)) err_reg_next = b;
      end else begin
        pend_err_next = sspr_pkg::ST_OVERFLOW;
      end
      if (past_len) begin
        if (len_v > cfg.length_limit) begin
          pend_err_next = sspr_pkg::ST_CORRUPT;
        end
        if (at_end) begin
          if (csum_ok) begin
            push                 = 1'b1;
            push_job.status      = sspr_pkg::ST_SUCCESS;
            push_job.servo_id    = (byte_count == CW'(2)) ? b : id_reg;
            push_job.servo_error = (len_v >= 8'd2) ? err_v : 8'd0;
            push_job.param_count = np_cap[sspr_pkg::NPW-1:0];
            armed_next           = 1'b0;
            in_packet_next       = 1'b0;
            sync_seen_next       = 2'd0;
            // hold the buffer until the back end has read the parameters
            locked_next          = 1'b1;
          end else begin
            pend_err_next = sspr_pkg::ST_CHECKSUM;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed      <= 1'b0;
      sync_seen  <= 2'd0;
      in_packet  <= 1'b0;
      byte_count <= '0;
      pend_err   <= sspr_pkg::ST_TIMEOUT;
      idle_ticks <= 16'd0;
      locked     <= 1'b0;
    end else begin
      armed      <= armed_next;
      sync_seen  <= sync_seen_next;
      in_packet  <= in_packet_next;
      byte_count <= byte_count_next;
      pend_err   <= pend_err_next;
      idle_ticks <= idle_ticks_next;
      locked     <= locked_next;
    end
  end

  always_ff @(posedge clk) begin
    id_reg    <= id_reg_next;
    len_reg   <= len_reg_next;
    err_reg   <= err_reg_next;
    sum_excl  <= sum_excl_next;
    last_byte <= last_byte_next;
  end

  no_write_locked: assert property (@(posedge clk) disable iff (rst) locked |-> !wr_en)
    else $error("packet buffer written while the back end reads it");

endmodule

FILE: hw/rtl/sspr_back.sv
// Back end: expands queued jobs into result items through an output register.
module sspr_back #(
  parameter int BUF_BYTES = 56,
  parameter int AW        = $clog2(BUF_BYTES)
) (
  input  logic              clk,
  input  logic              rst,
  input  sspr_pkg::job_t    q_job,
  input  logic              q_empty,
  output logic              pop,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  input  logic [7:0]        rd_data,
  output logic              result_valid,
  input  logic              result_ready,
  output sspr_pkg::result_t result,
  output logic              release_buf
);

  localparam int NPW = sspr_pkg::NPW;

  sspr_pkg::back_state_t state, state_next;
  logic [NPW-1:0] idx;
  logic [NPW-1:0] np;
  logic           out_accept;

  assign out_accept = result_valid && result_ready;

  always_comb begin
    state_next = state;
    unique case (state)
      sspr_pkg::BK_IDLE: begin
        if (!q_empty) begin
          state_next = (q_job.param_count != '0) ? sspr_pkg::BK_FETCH : sspr_pkg::BK_EMIT;
        end
      end
      sspr_pkg::BK_FETCH: state_next = sspr_pkg::BK_EMIT;
      sspr_pkg::BK_EMIT: begin
        if (out_accept) begin
          state_next = result.last ? sspr_pkg::BK_IDLE : sspr_pkg::BK_FETCH;
        end
      end
      default: state_next = sspr_pkg::BK_IDLE;
    endcase
  end

  always_comb begin
    pop          = 1'b0;
    rd_en        = 1'b0;
    rd_addr      = AW'(sspr_pkg::PARAM_BASE);
    result_valid = 1'b0;
    release_buf  = 1'b0;
    unique case (state)
      sspr_pkg::BK_IDLE: begin
        pop   = !q_empty;
        rd_en = !q_empty && (q_job.param_count != '0);
      end
      sspr_pkg::BK_FETCH: begin
      end
      sspr_pkg::BK_EMIT: begin
        result_valid = 1'b1;
        if (out_accept) begin
          if (result.last) begin
            release_buf = (result.status == sspr_pkg::ST_SUCCESS);
          end else begin
            // prefetch the next parameter
            rd_en   = 1'b1;
            rd_addr = AW'(sspr_pkg::PARAM_BASE) + AW'(idx) + AW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sspr_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      sspr_pkg::BK_IDLE: begin
        if (pop) begin
          idx                <= '0;
          np                 <= q_job.param_count;
          result.status      <= q_job.status;
          result.servo_id    <= q_job.servo_id;
          result.servo_error <= q_job.servo_error;
          result.param_byte  <= 8'd0;
          result.param_valid <= 1'b0;
          result.last        <= 1'b1;
        end
      end
      sspr_pkg::BK_FETCH: begin
        result.param_byte  <= rd_data;
        result.param_valid <= 1'b1;
        result.last        <= ((idx + NPW'(1)) == np);
      end
      sspr_pkg::BK_EMIT: begin
        if (out_accept && !result.last) begin
          idx <= idx + NPW'(1);
        end
      end
      default: begin
      end
    endcase
  end

  param_only_success: assert property (@(posedge clk) disable iff (rst)
      result_valid && result.param_valid |-> result.status == sspr_pkg::ST_SUCCESS)
    else $error("parameter byte carried by a failure result");
  failure_is_last: assert property (@(posedge clk) disable iff (rst)
      result_valid && result.status != sspr_pkg::ST_SUCCESS |-> result.last)
    else $error("failure result not marked last");

endmodule

FILE: hw/rtl/servo_status_packet_receiver_unit.sv
// Top level of the servo status packet receiver.
//
// Items enter on item_valid/item_ready: a start item arms a receive attempt,
// byte items carry received bus bytes, tick items advance the idle timer.
// The front end hunts for the two sync bytes, stores the packet in a buffer
// and checks length and checksum; each finished attempt becomes one job in a
// two-entry queue. The back end turns a job into result items on
// result_valid/result_ready: one per parameter byte (last flag on the final
// one), or a single item for a parameterless packet or a failure.
// The result item of a failure or an empty packet passes through the job
// queue and the back end's output register after the input item that ends
// the attempt; each parameter byte is first fetched through the buffer's
// registered read port and then offered. After each accepted result the back
// end passes through its fetch or idle state before it offers another.
// While a good packet's parameters are still being read out, the front end
// holds item_ready low; a stalled result side stops the back end only, until
// the queue fills. Reset disarms the receiver, empties the queue and loads
// timeout_ticks = 1000 and length_limit = 54; no buffer clearing is needed.
module servo_status_packet_receiver_unit #(
  parameter int BUF_BYTES   = 56,
  parameter int QUEUE_DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_ready,
  input  sspr_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_ready,
  output sspr_pkg::result_t result,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int AW = $clog2(BUF_BYTES);

  sspr_pkg::cfg_t cfg;
  sspr_pkg::job_t push_job;
  sspr_pkg::job_t q_job;
  logic           push, pop, q_full, q_empty;
  logic           wr_en, rd_en;
  logic [AW-1:0]  wr_addr, rd_addr;
  logic [7:0]     wr_data, rd_data;
  logic           release_buf;
  logic           cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= sspr_pkg::TIMEOUT_RESET;
      cfg.length_limit  <= sspr_pkg::LENGTH_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        sspr_pkg::REG_TIMEOUT:      cfg.timeout_ticks <= pwdata[15:0];
        sspr_pkg::REG_LENGTH_LIMIT: cfg.length_limit  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      sspr_pkg::REG_TIMEOUT:      prdata = {16'd0, cfg.timeout_ticks};
      sspr_pkg::REG_LENGTH_LIMIT: prdata = {24'd0, cfg.length_limit};
      default:                    prdata = 32'd0;
    endcase
  end

  sspr_front #(
    .BUF_BYTES (BUF_BYTES),
    .AW        (AW)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .item_valid  (item_valid),
    .item_ready  (item_ready),
    .item        (item),
    .cfg         (cfg),
    .q_full      (q_full),
    .push        (push),
    .push_job    (push_job),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .release_buf (release_buf)
  );

  sspr_buf #(
    .DEPTH (BUF_BYTES),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sspr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (q_job),
    .full     (q_full),
    .empty    (q_empty)
  );

  sspr_back #(
    .BUF_BYTES (BUF_BYTES),
    .AW        (AW)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_job        (q_job),
    .q_empty      (q_empty),
    .pop          (pop),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .release_buf  (release_buf)
  );

endmodule

FILE: tb/servo_status_packet_receiver_unit_test.sv
// Self-checking testbench for the servo status packet receiver unit.
module servo_status_packet_receiver_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BUF_BYTES = 56;
  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int ID_POS = 2;
  localparam int LEN_POS = 3;
  localparam int ERR_POS = 4;
  localparam logic [2:0] ADDR_TIMEOUT = {sspr_pkg::REG_TIMEOUT, 2'b00};
  localparam logic [2:0] ADDR_LENGTH_LIMIT = {sspr_pkg::REG_LENGTH_LIMIT, 2'b00};
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 1500;
  localparam int ITEMS_PER_PHASE = 66;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int REPORT_LIMIT = 10;

  // Tracks the receive attempt item by item and keeps the results still owed.
  class packet_scoreboard;
    int unsigned tick_limit;
    int unsigned max_length;
    bit listening;
    int sync_count;
    bit collecting;
    int stored;
    logic [7:0] frame [BUF_BYTES];
    logic [2:0] fail_code;
    int unsigned quiet_ticks;
    sspr_pkg::result_t expected_results[$];
    int errors;

    function new();
      tick_limit = sspr_pkg::TIMEOUT_RESET;
      max_length = sspr_pkg::LENGTH_LIMIT_RESET;
      listening = 1'b0;
      sync_count = 0;
      collecting = 1'b0;
      stored = 0;
      fail_code = sspr_pkg::ST_TIMEOUT;
      quiet_ticks = 0;
      errors = 0;
    endfunction

    function void set_register(logic idx, logic [31:0] value);
      if (idx == sspr_pkg::REG_TIMEOUT) tick_limit = value[15:0];
      else max_length = value[7:0];
    endfunction

    function void emit(logic [2:0] status, logic [7:0] id, logic [7:0] err,
                       logic [7:0] par, logic pv, logic last);
      sspr_pkg::result_t r;
      r.status = status;
      r.servo_id = id;
      r.servo_error = err;
      r.param_byte = par;
      r.param_valid = pv;
      r.last = last;
      expected_results.push_back(r);
    endfunction

    function void drop_attempt();
      listening = 1'b0;
      collecting = 1'b0;
      sync_count = 0;
    endfunction

    function void take_byte(logic [7:0] b);
      int len;
      int count;
      int i;
      logic [7:0] csum;
      if (!collecting) begin
        if (b == sspr_pkg::SYNC_BYTE) begin
          if (sync_count < 2) begin
            frame[sync_count] = b;
            sync_count++;
            stored = sync_count;
            quiet_ticks = 0;
          end
          return;
        end
        // lone sync byte: restart the hunt
        if (sync_count == 1) begin
          sync_count = 0;
          stored = 0;
          return;
        end
        if (sync_count != 2) return;
        collecting = 1'b1;
      end
      quiet_ticks = 0;
      if (stored < BUF_BYTES) begin
        frame[stored] = b;
        stored++;
      end else begin
        fail_code = sspr_pkg::ST_OVERFLOW;
      end
      if (stored < sspr_pkg::PKT_OVERHEAD) return;
      len = frame[LEN_POS];
      if (len > max_length) fail_code = sspr_pkg::ST_CORRUPT;
      if (stored - sspr_pkg::PKT_OVERHEAD != len) return;
      csum = '0;
      for (i = ID_POS; i <= len + ID_POS; i++) csum = csum + frame[i];
      if (~csum != frame[len + LEN_POS]) begin
        fail_code = sspr_pkg::ST_CHECKSUM;
        return;
      end
      drop_attempt();
      count = (len >= 2) ? len - 2 : 0;
      if (count == 0) begin
        emit(sspr_pkg::ST_SUCCESS, frame[ID_POS], (len >= 2) ? frame[ERR_POS] : 8'h00,
             8'h00, 1'b0, 1'b1);
      end else begin
        if (count > sspr_pkg::MAX_RESULTS) count = sspr_pkg::MAX_RESULTS;
        for (i = 0; i < count; i++)
          emit(sspr_pkg::ST_SUCCESS, frame[ID_POS], frame[ERR_POS],
               frame[sspr_pkg::PARAM_BASE + i], 1'b1, i == count - 1);
      end
    endfunction

    // Returns 1 for a start item, or for a byte or tick item while an attempt is armed.
    function bit note_item(sspr_pkg::item_t it);
      if (it.mode == sspr_pkg::MODE_START) begin
        listening = 1'b1;
        sync_count = 0;
        collecting = 1'b0;
        stored = 0;
        fail_code = sspr_pkg::ST_TIMEOUT;
        quiet_ticks = 0;
        return 1'b1;
      end
      if (!listening || it.mode == MODE_UNUSED) return 1'b0;
      if (it.mode == sspr_pkg::MODE_BYTE) begin
        take_byte(it.rx_byte);
      end else begin
        if (quiet_ticks < 16'hFFFF) quiet_ticks++;
        if (quiet_ticks >= tick_limit) begin
          drop_attempt();
          emit(fail_code, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1);
        end
      end
      return 1'b1;
    endfunction

    function string describe(sspr_pkg::result_t r);
      return $sformatf("status %0d id %02h error %02h param %02h valid %0b last %0b",
                       r.status, r.servo_id, r.servo_error, r.param_byte,
                       r.param_valid, r.last);
    endfunction

    function void fail(string msg);
      errors++;
      if (errors <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(sspr_pkg::result_t got);
      sspr_pkg::result_t want;
      if (expected_results.size() == 0) begin
        fail($sformatf("unexpected result: %s", describe(got)));
        return;
      end
      want = expected_results.pop_front();
      if (got.status !== want.status || got.servo_id !== want.servo_id ||
          got.servo_error !== want.servo_error || got.param_byte !== want.param_byte ||
          got.param_valid !== want.param_valid || got.last !== want.last)
        fail($sformatf("result mismatch: expected %s, got %s",
                       describe(want), describe(got)));
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic item_valid = 1'b0;
  logic item_ready;
  sspr_pkg::item_t item_bus = '0;
  logic result_valid;
  logic result_ready = 1'b0;
  sspr_pkg::result_t result_bus;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  packet_scoreboard scoreboard = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int items_taken = 0;
  int cycle_count = 0;

  servo_status_packet_receiver_unit #(
    .BUF_BYTES(BUF_BYTES)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .item(item_bus),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .result(result_bus),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("servo_status_packet_receiver_unit_test NOT OK");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) scoreboard.check_result(result_bus);
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_ready <= 1'b0;
      end else begin
        result_ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  task automatic send_item(input logic [1:0] mode, input logic [7:0] b);
    sspr_pkg::item_t it;
    it.mode = mode;
    it.rx_byte = b;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item_bus <= it;
    do @(posedge clk); while (!item_ready);
    if (scoreboard.note_item(it)) items_taken++;
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    scoreboard.set_register(addr[2], data);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drop valid and let every owed result come out before touching registers.
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (scoreboard.expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_packet(input logic [7:0] id, input int len, input bit bad_sum,
                             input int body, input bit extra_sync);
    logic [7:0] csum;
    logic [7:0] b;
    int i;
    csum = id + len[7:0];
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    if (extra_sync) send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, id);
    send_item(sspr_pkg::MODE_BYTE, len[7:0]);
    for (i = 0; i < body; i++) begin
      if ($urandom_range(49) == 0) send_item(sspr_pkg::MODE_TICK, 8'($urandom));
      if (i == len - 1) begin
        b = ~csum;
        if (bad_sum) b = b ^ 8'(1 << $urandom_range(7));
      end else begin
        b = 8'($urandom);
        csum = csum + b;
      end
      send_item(sspr_pkg::MODE_BYTE, b);
    end
  endtask

  // Tick until the attempt ends, bounded for long timeouts.
  task automatic finish_attempt();
    int n;
    n = 0;
    while (scoreboard.listening && n < 12) begin
      send_item(sspr_pkg::MODE_TICK, 8'($urandom));
      n++;
    end
  endtask

  task automatic random_packet(input bit force_overflow);
    logic [7:0] id;
    int len;
    int body;
    int r;
    bit bad_sum;
    bit extra_sync;
    if ($urandom_range(9) == 0) send_item(MODE_UNUSED, 8'($urandom));
    if ($urandom_range(19) != 0) send_item(sspr_pkg::MODE_START, 8'($urandom));
    r = $urandom_range(7);
    if (r == 0) begin
      send_item(sspr_pkg::MODE_BYTE, 8'($urandom_range(254)));
    end else if (r == 1) begin
      send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
      send_item(sspr_pkg::MODE_BYTE, 8'($urandom_range(254)));
    end
    id = ($urandom_range(15) == 0) ? sspr_pkg::SYNC_BYTE : 8'($urandom_range(254));
    r = $urandom_range(99);
    if (force_overflow || r >= 96) len = 53 + $urandom_range(force_overflow ? 100 : 202);
    else if (r < 8) len = $urandom_range(1);
    else if (r < 82) len = 2 + $urandom_range(8);
    else len = 11 + $urandom_range(43);
    bad_sum = ($urandom_range(9) == 0);
    body = ($urandom_range(14) == 0) ? $urandom_range(len) : len;
    if (body > 60) body = 60;
    extra_sync = ($urandom_range(11) == 0);
    send_packet(id, len, bad_sum, body, extra_sync);
    finish_attempt();
  endtask

  initial begin
    int phase;
    int target;
    int tmo;
    int lim;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Disarmed: all ignored
    send_item(sspr_pkg::MODE_TICK, 8'h00);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(MODE_UNUSED, 8'hA5);
    // Sync hunt corner cases, then a packet with one parameter
    send_item(sspr_pkg::MODE_START, 8'h00);
    send_item(sspr_pkg::MODE_BYTE, 8'h00);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, 8'h5A);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, 8'hFE);
    send_item(sspr_pkg::MODE_BYTE, 8'h03);
    send_item(sspr_pkg::MODE_BYTE, 8'hFF);
    send_item(sspr_pkg::MODE_BYTE, 8'hFF);
    send_item(sspr_pkg::MODE_BYTE, 8'h00);
    // Restart mid-packet, then a packet too short for an error byte
    send_item(sspr_pkg::MODE_START, 8'hFF);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, 8'h33);
    send_item(sspr_pkg::MODE_START, 8'h00);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, sspr_pkg::SYNC_BYTE);
    send_item(sspr_pkg::MODE_BYTE, 8'h00);
    send_item(sspr_pkg::MODE_BYTE, 8'h01);
    send_item(sspr_pkg::MODE_BYTE, 8'hFE);
    // Zero timeout: first tick ends the attempt
    drain();
    write_reg(ADDR_TIMEOUT, 32'd0);
    send_item(sspr_pkg::MODE_START, 8'h00);
    send_item(sspr_pkg::MODE_TICK, 8'h00);

    for (phase = 0; phase < 5; phase++) begin
      drain();
      case (phase)
        0: begin
          tmo = 4; lim = 54; idle_pct = 0; stall_pct = 0;
        end
        1: begin
          tmo = 1; lim = 255; idle_pct = 84; stall_pct = 0;
        end
        2: begin
          tmo = 65535; lim = 0; idle_pct = 0; stall_pct = 84;
        end
        3: begin
          tmo = 7; lim = 200; idle_pct = 36; stall_pct = 36;
        end
        default: begin
          tmo = 5; lim = 54; idle_pct = 0; stall_pct = 0;
        end
      endcase
      write_reg(ADDR_TIMEOUT, 32'(tmo));
      write_reg(ADDR_LENGTH_LIMIT, 32'(lim));
      // Last phase: hold the result side off so the job queue backs up
      if (phase == 4) hold_req = HOLD_CYCLES;
      target = items_taken + ITEMS_PER_PHASE;
      random_packet(phase == 3);
      while (items_taken < target) random_packet(1'b0);
    end

    drain();
    if (scoreboard.errors == 0) begin
      $display("servo_status_packet_receiver_unit_test OK");
    end else begin
      $display("servo_status_packet_receiver_unit_test NOT OK");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/sspr_pkg.sv
hw/rtl/sspr_buf.sv
hw/rtl/sspr_queue.sv
hw/rtl/sspr_front.sv
hw/rtl/sspr_back.sv
hw/rtl/servo_status_packet_receiver_unit.sv
tb/servo_status_packet_receiver_unit_test.sv
